// ===== sv/tro_pkg.sv =====
// tro_pkg: shared types and byte codes for the Telnet receive negotiator.
// Used by tro_parse, tro_emit, the top level and the port checker.
`default_nettype none
package tro_pkg;

    // Telnet command bytes
    localparam logic [7:0] B_IAC  = 8'd255;
    localparam logic [7:0] B_DONT = 8'd254;
    localparam logic [7:0] B_DO   = 8'd253;
    localparam logic [7:0] B_WONT = 8'd252;
    localparam logic [7:0] B_WILL = 8'd251;
    localparam logic [7:0] B_SB   = 8'd250;
    localparam logic [7:0] B_EL   = 8'd248;
    localparam logic [7:0] B_EC   = 8'd247;
    localparam logic [7:0] B_AYT  = 8'd246;
    localparam logic [7:0] B_SE   = 8'd240;

    // Option codes
    localparam logic [7:0] OPT_ECHO  = 8'd1;
    localparam logic [7:0] OPT_SGA   = 8'd3;
    localparam logic [7:0] OPT_TTYPE = 8'd24;
    localparam logic [7:0] OPT_NAWS  = 8'd31;
    localparam logic [7:0] TT_IS     = 8'd0;
    localparam logic [7:0] TT_SEND   = 8'd1;

    // Subnegotiation byte limits
    localparam int NAWS_MAX_DEF  = 21;
    localparam int TTYPE_MAX_DEF = 61;
    localparam int SubCountW     = 7;

    // Parser modes
    typedef enum logic [2:0] {
        M_DATA, M_IAC, M_VERB, M_SBOPT, M_NAWS, M_TTYPE, M_TTAIL, M_SKIP
    } t_mode;

    // Pending negotiation verb, in wire order from WILL
    typedef enum logic [1:0] {
        V_WILL, V_WONT, V_DO, V_DONT
    } t_verb;

    // Result kinds
    typedef enum logic [2:0] {
        K_DATA, K_XMIT, K_EC, K_EL, K_AYT, K_WINSZ, K_NAME, K_NAMEEND
    } t_kind;

    // Burst shape: one result, a 3-byte reply, or reply plus TTYPE SEND request
    typedef enum logic [1:0] {
        SH_ONE, SH_CMD, SH_TTREQ
    } t_shape;

    // Everything one received byte asks the emitter to send
    typedef struct packed {
        t_shape      shape;
        t_kind       kind;
        logic [7:0]  data;
        t_verb       verb;
        logic [15:0] width;
        logic [15:0] height;
        logic        echo;
    } t_burst;

endpackage
`default_nettype wire

// ===== sv/tro_parse.sv =====
// tro_parse: Telnet receive parser state and per-byte burst decode.
// Depends on tro_pkg.
`default_nettype none
module tro_parse #(
    parameter int NAWS_MAX_BYTES  = tro_pkg::NAWS_MAX_DEF,
    parameter int TTYPE_MAX_BYTES = tro_pkg::TTYPE_MAX_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_take,
    output logic                 o_emit,
    output tro_pkg::t_burst      o_burst
);
    import tro_pkg::*;

    localparam logic [SubCountW-1:0] NawsLim  = SubCountW'(NAWS_MAX_BYTES);
    localparam logic [SubCountW-1:0] TtypeLim = SubCountW'(TTYPE_MAX_BYTES);

    t_mode                r_mode, n_mode;
    t_verb                r_verb, n_verb;
    logic                 r_esc, n_esc;
    logic [SubCountW-1:0] r_cnt, n_cnt;
    logic [15:0]          r_width, n_width;
    logic [15:0]          r_height, n_height;
    logic                 r_field, n_field;
    logic                 r_echo, n_echo;

    logic                 sub_hold, sub_end, sub_full, sub_byte;
    logic [SubCountW-1:0] sub_lim;
    logic                 opt_ok;

    // Subnegotiation byte classification
    always_comb begin
        sub_lim  = (r_mode == M_NAWS) ? NawsLim : TtypeLim;
        sub_hold = !r_esc && (i_byte == B_IAC);
        sub_end  = r_esc && (i_byte == B_SE);
        sub_full = (r_cnt >= sub_lim);
        sub_byte = !sub_hold && !sub_end && !sub_full;
        opt_ok   = (i_byte == OPT_NAWS) || (i_byte == OPT_ECHO) ||
                   (i_byte == OPT_TTYPE) || (i_byte == OPT_SGA);
    end

    // Next state and burst decode
    always_comb begin
        n_mode   = r_mode;
        n_verb   = r_verb;
        n_esc    = r_esc;
        n_cnt    = r_cnt;
        n_width  = r_width;
        n_height = r_height;
        n_field  = r_field;
        n_echo   = r_echo;
        o_emit   = 1'b0;
        o_burst.shape  = SH_ONE;
        o_burst.kind   = K_DATA;
        o_burst.data   = 8'd0;
        o_burst.verb   = V_WILL;
        o_burst.width  = 16'd0;
        o_burst.height = 16'd0;

        unique case (r_mode)
            M_IAC: begin
                n_mode = M_DATA;
                if (i_byte == B_IAC) begin
                    o_emit       = 1'b1;
                    o_burst.data = B_IAC;
                end else if (i_byte == B_EC) begin
                    o_emit       = 1'b1;
                    o_burst.kind = K_EC;
                end else if (i_byte == B_EL) begin
                    o_emit       = 1'b1;
                    o_burst.kind = K_EL;
                end else if (i_byte == B_AYT) begin
                    o_emit       = 1'b1;
                    o_burst.kind = K_AYT;
                end else if (i_byte == B_SB) begin
                    n_mode = M_SBOPT;
                end else if (i_byte >= B_WILL) begin
                    n_verb = t_verb'(2'(i_byte - B_WILL));
                    n_mode = M_VERB;
                end
            end
            M_VERB: begin
                n_mode        = M_DATA;
                o_burst.shape = SH_CMD;
                o_burst.data  = i_byte;
                unique case (r_verb)
                    V_WILL: begin
                        o_emit = 1'b1;
                        if (i_byte == OPT_ECHO) begin
                            o_burst.verb = V_DONT;
                        end else if (opt_ok) begin
                            o_burst.verb = V_DO;
                            if (i_byte == OPT_TTYPE) begin
                                o_burst.shape = SH_TTREQ;
                            end
                        end else begin
                            o_burst.verb = V_DONT;
                        end
                    end
                    V_DO: begin
                        o_emit = 1'b1;
                        if (opt_ok) begin
                            o_burst.verb = V_WILL;
                            if (i_byte == OPT_ECHO) begin
                                n_echo = 1'b1;
                            end
                        end else begin
                            o_burst.verb = V_WONT;
                        end
                    end
                    V_DONT: begin
                        o_emit       = 1'b1;
                        o_burst.verb = V_WONT;
                        if (i_byte == OPT_ECHO) begin
                            n_echo = 1'b0;
                        end
                    end
                    V_WONT: begin
                        o_emit = 1'b0;
                    end
                    default: begin
                        o_emit = 1'b0;
                    end
                endcase
            end
            M_SBOPT: begin
                n_esc = 1'b0;
                n_cnt = '0;
                if (i_byte == OPT_NAWS) begin
                    n_width  = 16'd0;
                    n_height = 16'd0;
                    n_mode   = M_NAWS;
                end else if (i_byte == OPT_TTYPE) begin
                    n_field = 1'b0;
                    n_mode  = M_TTYPE;
                end else begin
                    n_mode = M_SKIP;
                end
            end
            M_NAWS: begin
                n_esc = sub_hold;
                if (sub_end || (!sub_hold && sub_full)) begin
                    n_mode = M_DATA;
                end else if (sub_byte) begin
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == SubCountW'(0)) begin
                        n_width = {i_byte, 8'd0};
                    end else if (r_cnt == SubCountW'(1)) begin
                        n_width = {r_width[15:8], r_width[7:0] | i_byte};
                    end else if (r_cnt == SubCountW'(2)) begin
                        n_height = {i_byte, 8'd0};
                    end else if (r_cnt == SubCountW'(3)) begin
                        n_height       = {r_height[15:8], r_height[7:0] | i_byte};
                        o_emit         = 1'b1;
                        o_burst.kind   = K_WINSZ;
                        o_burst.width  = r_width;
                        o_burst.height = {r_height[15:8], r_height[7:0] | i_byte};
                    end
                end
            end
            M_TTYPE, M_TTAIL: begin
                n_esc = sub_hold;
                if (sub_end || (!sub_hold && sub_full)) begin
                    o_emit       = 1'b1;
                    o_burst.kind = K_NAMEEND;
                    n_mode       = M_DATA;
                end else if (sub_byte) begin
                    n_cnt = r_cnt + 1'b1;
                    if (r_mode == M_TTYPE) begin
                        o_burst.kind = K_NAME;
                        o_burst.data = i_byte;
                        if (!r_field) begin
                            n_field = 1'b1;
                            o_emit  = (i_byte != TT_IS);
                        end else if (i_byte != B_IAC) begin
                            o_emit = 1'b1;
                        end else begin
                            n_mode = M_TTAIL;
                        end
                    end
                end
            end
            M_SKIP: begin
                n_esc = sub_hold;
                if (sub_end) begin
                    n_mode = M_DATA;
                end
            end
            M_DATA: begin
                if (i_byte == B_IAC) begin
                    n_mode = M_IAC;
                end else begin
                    o_emit       = 1'b1;
                    o_burst.data = i_byte;
                end
            end
            default: begin
                n_mode = M_DATA;
            end
        endcase
        o_burst.echo = n_echo;
    end

    // Parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_DATA;
            r_verb   <= V_WILL;
            r_esc    <= 1'b0;
            r_cnt    <= '0;
            r_width  <= 16'd0;
            r_height <= 16'd0;
            r_field  <= 1'b0;
            r_echo   <= 1'b0;
        end else if (i_take) begin
            r_mode   <= n_mode;
            r_verb   <= n_verb;
            r_esc    <= n_esc;
            r_cnt    <= n_cnt;
            r_width  <= n_width;
            r_height <= n_height;
            r_field  <= n_field;
            r_echo   <= n_echo;
        end
    end

endmodule
`default_nettype wire

// ===== sv/tro_emit.sv =====
// tro_emit: burst register and serializer, one result word per cycle while the receiver is ready.
// Depends on tro_pkg.
`default_nettype none
module tro_emit (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire tro_pkg::t_burst i_burst,
    output logic                 o_free,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [2:0]           o_kind,
    output logic [7:0]           o_byte_value,
    output logic [15:0]          o_win_width,
    output logic [15:0]          o_win_height,
    output logic                 o_echo_on,
    output logic                 o_last
);
    import tro_pkg::*;

    logic        r_valid;
    t_burst      r_burst;
    logic [3:0]  r_idx;
    logic [3:0]  last_idx;
    logic        done;
    logic [7:0]  verb_byte;
    logic [7:0]  cmd_byte;

    // Sequence byte for reply bursts
    always_comb begin
        verb_byte = B_WILL + 8'(r_burst.verb);
        unique case (r_idx)
            4'd0:    cmd_byte = B_IAC;
            4'd1:    cmd_byte = verb_byte;
            4'd2:    cmd_byte = r_burst.data;
            4'd3:    cmd_byte = B_IAC;
            4'd4:    cmd_byte = B_SB;
            4'd5:    cmd_byte = OPT_TTYPE;
            4'd6:    cmd_byte = TT_SEND;
            4'd7:    cmd_byte = B_IAC;
            4'd8:    cmd_byte = B_SE;
            default: cmd_byte = 8'd0;
        endcase
    end

    // Output word mux
    always_comb begin
        unique case (r_burst.shape)
            SH_CMD:   last_idx = 4'd2;
            SH_TTREQ: last_idx = 4'd8;
            default:  last_idx = 4'd0;
        endcase
        o_valid      = r_valid;
        o_last       = (r_idx == last_idx);
        o_echo_on    = r_burst.echo;
        o_win_width  = r_burst.width;
        o_win_height = r_burst.height;
        if (r_burst.shape == SH_ONE) begin
            o_kind       = 3'(r_burst.kind);
            o_byte_value = r_burst.data;
        end else begin
            o_kind       = 3'(K_XMIT);
            o_byte_value = cmd_byte;
        end
        done   = r_valid && i_ready && o_last;
        o_free = !r_valid || done;
    end

    // Burst register and word index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 4'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= 4'd0;
        end else if (done) begin
            r_valid <= 1'b0;
            r_idx   <= 4'd0;
        end else if (r_valid && i_ready) begin
            r_idx <= r_idx + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_burst <= i_burst;
        end
    end

endmodule
`default_nettype wire

// ===== sv/telnet_rx_option_negotiator.sv =====
// Telnet receive option negotiator, top level.
// Depends on tro_pkg, tro_parse and tro_emit.
//
// Usage:
//   Receive channel: i_rx_byte with i_rx_valid / o_rx_ready, one peer byte per
//   word. Result channel: o_res_valid / i_res_ready carrying o_kind,
//   o_byte_value, o_win_width, o_win_height, o_echo_on and o_last.
//   Each received byte is decoded in the cycle it is accepted and its results
//   are loaded into a burst register; the first result word appears in the cycle
//   after acceptance. A byte yields 0 to 9 words, o_last marking its final one.
//   Throughput: one byte per cycle while each byte yields at most one word and
//   the receiver is ready. A negotiation reply is 3 result words, a WILL TTYPE
//   reply 9 words; o_rx_ready is high when the burst register is empty or its last
//   word is being taken, so the receive side waits out the rest of a burst.
//   Bytes that yield nothing still need the burst register to be free.
//   If the receiver stalls, the current word holds and o_rx_ready stays low
//   until the last word of the burst is taken.
//   Reset (synchronous, active low) returns the parser to plain data mode,
//   clears echo and subnegotiation state and empties the burst register.
`default_nettype none
module telnet_rx_option_negotiator #(
    parameter int NAWS_MAX_BYTES  = tro_pkg::NAWS_MAX_DEF,
    parameter int TTYPE_MAX_BYTES = tro_pkg::TTYPE_MAX_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_rx_valid,
    output logic             o_rx_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_res_valid,
    input  wire logic        i_res_ready,
    output logic [2:0]       o_kind,
    output logic [7:0]       o_byte_value,
    output logic [15:0]      o_win_width,
    output logic [15:0]      o_win_height,
    output logic             o_echo_on,
    output logic             o_last
);
    import tro_pkg::*;

    logic   take;
    logic   emit;
    logic   free;
    t_burst burst;

    assign o_rx_ready = free;
    assign take       = i_rx_valid && free;

    // Byte parser
    tro_parse #(
        .NAWS_MAX_BYTES  (NAWS_MAX_BYTES),
        .TTYPE_MAX_BYTES (TTYPE_MAX_BYTES)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_rx_byte),
        .i_take  (take),
        .o_emit  (emit),
        .o_burst (burst)
    );

    // Result serializer
    tro_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (take && emit),
        .i_burst      (burst),
        .o_free       (free),
        .o_valid      (o_res_valid),
        .i_ready      (i_res_ready),
        .o_kind       (o_kind),
        .o_byte_value (o_byte_value),
        .o_win_width  (o_win_width),
        .o_win_height (o_win_height),
        .o_echo_on    (o_echo_on),
        .o_last       (o_last)
    );

endmodule
`default_nettype wire

// ===== sv/tro_check.sv =====
// tro_check: port-level checks for telnet_rx_option_negotiator, with bind.
// Depends on tro_pkg.
`default_nettype none
module tro_check (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_rx_ready,
    input wire logic        o_res_valid,
    input wire logic        i_res_ready,
    input wire logic [2:0]  o_kind,
    input wire logic [15:0] o_win_width,
    input wire logic [15:0] o_win_height,
    input wire logic        o_echo_on,
    input wire logic        o_last
);
    import tro_pkg::*;

    // A stalled result word stays up
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid)
        else $error("result word dropped while stalled");

    // No new byte taken while a burst has words still to go
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_last |-> !o_rx_ready)
        else $error("byte accepted in the middle of a burst");

    // A burst continues with the same echo flag
    a_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_ready && !o_last |=>
            o_res_valid && (o_echo_on == $past(o_echo_on)))
        else $error("echo flag changed within a burst");

    // Multi-word bursts are reply bytes only
    a_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_last |-> o_kind == 3'(K_XMIT))
        else $error("non-reply word in a multi-word burst");

    // Window size fields are zero except on window size words
    a_winsz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_kind != 3'(K_WINSZ)) |->
            (o_win_width == 16'd0) && (o_win_height == 16'd0))
        else $error("window size on a non window size word");

endmodule

bind telnet_rx_option_negotiator tro_check u_check (.*);
`default_nettype wire
